// ===== sv/integer_list_parse_and_check_core_assert.svh =====
// Assertion macros for the integer list parse and check core.
`ifndef INTEGER_LIST_PARSE_AND_CHECK_CORE_ASSERT_SVH
`define INTEGER_LIST_PARSE_AND_CHECK_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define ILPC_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ILPC_IMPLY(name, ante, cons, msg) \
  `ILPC_CHECK(name, (ante) |-> (cons), msg)

`endif

// ===== sv/ilpc_pkg.sv =====
// Shared types and constants for the integer list parse and check core.
`timescale 1ns / 1ps

package ilpc_pkg;

  localparam int unsigned MAX_VALUES_DEF = 1024;
  localparam int unsigned DATA_W         = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [DATA_W-1:0] MAG_CAP = 32'h8000_0000;

  localparam logic [1:0] ST_PENDING  = 2'd0;
  localparam logic [1:0] ST_UNSORTED = 2'd1;
  localparam logic [1:0] ST_SORTED   = 2'd2;
  localparam logic [1:0] ST_ERROR    = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic start_tok;
    logic scan;
    logic commit;
    logic emit;
  } ilpc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need;
    logic scan_needed;
    logic scan_done;
    logic result_pend;
    logic out_free;
  } ilpc_sts_t;

endpackage

// ===== sv/ilpc_ctrl.sv =====
// Controller state machine: sequences parse, duplicate scan, store and result.
`timescale 1ns / 1ps

module ilpc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ilpc_pkg::ilpc_sts_t sts_i,
  output ilpc_pkg::ilpc_cmd_t cmd_o
);
  import ilpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_COMMIT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.need) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.start_tok = 1'b1;
          state_d = sts_i.scan_needed ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.result_pend) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== sv/ilpc_dp.sv =====
// Datapath: token parser, value store with duplicate scan, order tracking, result register.
`timescale 1ns / 1ps

module ilpc_dp #(
  parameter int unsigned MAX_VALUES = ilpc_pkg::MAX_VALUES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                split_mode_i,
  input  logic [7:0]          ch_i,
  input  logic                has_char_i,
  input  logic                end_of_token_i,
  input  logic                end_of_list_i,
  input  ilpc_pkg::ilpc_cmd_t cmd_i,
  output ilpc_pkg::ilpc_sts_t sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic signed [31:0]  value_o,
  output logic                value_valid_o,
  output logic                done_res_o,
  output logic [1:0]          status_o
);
  import ilpc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VALUES);
  localparam int unsigned CW = $clog2(MAX_VALUES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VALUES);

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_SIGN,
    PH_DIGITS
  } phase_e;

  logic [DATA_W-1:0] store_q [MAX_VALUES];

  logic [DATA_W-1:0] mag_q;
  logic              neg_q;
  phase_e            phase_q;
  logic              eot_q, eol_q, space_q;
  logic              tok_q, err_q, sorted_q;
  logic [DATA_W-1:0] prev_q, val_q, rd_data_q;
  logic [CW-1:0]     cnt_q, rd_cnt_q;
  logic              rd_vld_q;
  logic              out_valid_q;

  logic              is_digit, is_sign, is_sep;
  logic [35:0]       mag_ext, mag_x10;
  logic [DATA_W-1:0] mag_next, tok_val;
  logic              mag_err, full, err_now, issue, store_en;

  always_comb begin
    is_digit = ch_i inside {[CH_ZERO:CH_NINE]};
    is_sign  = (ch_i == CH_MINUS) || (ch_i == CH_PLUS);
    is_sep   = has_char_i && split_mode_i && (ch_i == CH_SPACE);
    // times ten as two shifts, then saturate
    mag_ext  = {4'b0, mag_q};
    mag_x10  = (mag_ext << 3) + (mag_ext << 1) + 36'(ch_i - CH_ZERO);
    mag_next = (mag_x10 > 36'(MAG_CAP)) ? MAG_CAP : mag_x10[DATA_W-1:0];
    mag_err  = mag_q[DATA_W-1];
    tok_val  = neg_q ? (32'd0 - mag_q) : mag_q;
    full     = (cnt_q >= CNT_MAX);
    err_now  = err_q || mag_err || full;
    issue    = cmd_i.scan && (rd_cnt_q < cnt_q);
    store_en = cmd_i.commit && !err_q;

    sts_o.need        = space_q
                      || (eot_q && ((phase_q != PH_EMPTY) || !split_mode_i))
                      || (eol_q && (phase_q != PH_EMPTY));
    sts_o.scan_needed = !err_now && (cnt_q != '0);
    sts_o.scan_done   = rd_vld_q && (rd_cnt_q == cnt_q);
    sts_o.result_pend = tok_q || eol_q;
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      neg_q       <= 1'b0;
      phase_q     <= PH_EMPTY;
      eot_q       <= 1'b0;
      eol_q       <= 1'b0;
      space_q     <= 1'b0;
      tok_q       <= 1'b0;
      err_q       <= 1'b0;
      sorted_q    <= 1'b1;
      prev_q      <= '0;
      cnt_q       <= '0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        eot_q   <= end_of_token_i;
        eol_q   <= end_of_list_i;
        space_q <= is_sep && (phase_q != PH_EMPTY);
        if (has_char_i && !is_sep) begin
          if (is_digit) begin
            mag_q   <= mag_next;
            phase_q <= PH_DIGITS;
          end else if (is_sign && (phase_q == PH_EMPTY)) begin
            neg_q   <= (ch_i == CH_MINUS);
            phase_q <= PH_SIGN;
          end else begin
            err_q <= 1'b1;
          end
        end
      end

      if (cmd_i.start_tok) begin
        tok_q    <= 1'b1;
        mag_q    <= '0;
        neg_q    <= 1'b0;
        phase_q  <= PH_EMPTY;
        rd_cnt_q <= '0;
        rd_vld_q <= 1'b0;
        if (mag_err || full) begin
          err_q <= 1'b1;
        end
      end

      if (cmd_i.scan) begin
        rd_vld_q <= issue;
        if (issue) begin
          rd_cnt_q <= rd_cnt_q + 1'b1;
        end
        if (rd_vld_q && (rd_data_q == val_q)) begin
          err_q <= 1'b1;
        end
      end

      if (store_en) begin
        cnt_q  <= cnt_q + 1'b1;
        prev_q <= val_q;
        if ((cnt_q != '0) && ($signed(prev_q) > $signed(val_q))) begin
          sorted_q <= 1'b0;
        end
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        tok_q       <= 1'b0;
        if (eol_q) begin
          // list done: drop all list state
          cnt_q    <= '0;
          prev_q   <= '0;
          sorted_q <= 1'b1;
          err_q    <= 1'b0;
          mag_q    <= '0;
          neg_q    <= 1'b0;
          phase_q  <= PH_EMPTY;
          eol_q    <= 1'b0;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Value store and token value latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_tok) begin
      val_q <= tok_val;
    end
    if (issue) begin
      rd_data_q <= store_q[rd_cnt_q[AW-1:0]];
    end
    if (store_en) begin
      store_q[cnt_q[AW-1:0]] <= val_q;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      value_o       <= (tok_q && !err_q) ? $signed(val_q) : 32'sd0;
      value_valid_o <= tok_q && !err_q;
      done_res_o    <= eol_q;
      if (!eol_q) begin
        status_o <= ST_PENDING;
      end else if (err_q) begin
        status_o <= ST_ERROR;
      end else if (sorted_q) begin
        status_o <= ST_SORTED;
      end else begin
        status_o <= ST_UNSORTED;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/integer_list_parse_and_check_core.sv =====
// Top level of the integer list parse and check core.
// Takes argument text one character per item and parses decimal integers with an optional
// leading sign; tokens end by flag, or also at spaces when split_mode is set. Each value is
// checked against every stored value for duplicates, stored, and tracked for nondecreasing
// order; the item that ends the list reports 1 unsorted, 2 sorted or 3 error, then clears
// the list. An item that completes a token goes through a duplicate scan unless the store is
// empty or full, the value overflows or the list is already in error; the scan reads the
// value store one entry per cycle through its single read port. A held result stalls only
// the final step.
`timescale 1ns / 1ps

module integer_list_parse_and_check_core #(
  parameter int unsigned MAX_VALUES = ilpc_pkg::MAX_VALUES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         ch_i,
  input  logic               has_char_i,
  input  logic               end_of_token_i,
  input  logic               end_of_list_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               value_valid_o,
  output logic               done_res_o,
  output logic [1:0]         status_o
);
  import ilpc_pkg::*;

  logic      split_mode_q;
  logic      reg_sel;
  ilpc_cmd_t cmd;
  ilpc_sts_t sts;

  assign reg_sel = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {31'b0, split_mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && reg_sel) begin
      split_mode_q <= pwdata[0];
    end
  end

  ilpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ilpc_dp #(
    .MAX_VALUES (MAX_VALUES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .split_mode_i   (split_mode_q),
    .ch_i           (ch_i),
    .has_char_i     (has_char_i),
    .end_of_token_i (end_of_token_i),
    .end_of_list_i  (end_of_list_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .value_o        (value_o),
    .value_valid_o  (value_valid_o),
    .done_res_o     (done_res_o),
    .status_o       (status_o)
  );

`include "integer_list_parse_and_check_core_assert.svh"

  `ILPC_CHECK(a_busy_after_take, in_valid_i && !in_stall_o |=> in_stall_o, "input open after take")
  `ILPC_IMPLY(a_mid_list_pending, out_valid_o && !done_res_o, status_o == ST_PENDING, "mid-list status")
  `ILPC_IMPLY(a_invalid_is_zero, out_valid_o && !value_valid_o, value_o == 32'sd0, "nonzero invalid value")
  `ILPC_IMPLY(a_valid_no_error, out_valid_o && value_valid_o, status_o != ST_ERROR, "valid value on error")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the integer list parse and check core.
`timescale 1ns / 1ps

module testbench;
  import ilpc_pkg::*;

  localparam int unsigned STORE_DEPTH  = MAX_VALUES_DEF;
  localparam logic [2:0]  REG_SPLIT    = 3'd0;
  localparam logic [31:0] INT_TOP      = 32'h7FFF_FFFF;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam int unsigned N_EXTREMES   = 10;

  typedef enum logic [1:0] {
    TOK_EMPTY,
    TOK_SIGN,
    TOK_DIGITS
  } tok_phase_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic               value_valid;
    logic               done_res;
    logic [1:0]         status;
  } list_result_t;

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [2:0]         paddr          = '0;
  logic [31:0]        pwdata         = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [7:0]         ch_i           = '0;
  logic               has_char_i     = 1'b0;
  logic               end_of_token_i = 1'b0;
  logic               end_of_list_i  = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic signed [31:0] value_o;
  logic               value_valid_o;
  logic               done_res_o;
  logic [1:0]         status_o;

  integer_list_parse_and_check_core #(
    .MAX_VALUES(STORE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ch_i          (ch_i),
    .has_char_i    (has_char_i),
    .end_of_token_i(end_of_token_i),
    .end_of_list_i (end_of_list_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value_o),
    .value_valid_o (value_valid_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Parser state as the block should hold it
  logic [31:0] kept_values [STORE_DEPTH];
  int unsigned kept_count;
  logic [31:0] tok_mag;
  logic        tok_neg;
  tok_phase_e  tok_phase;
  logic [31:0] last_kept;
  logic        order_ok;
  logic        list_err;
  logic        split_on;

  list_result_t awaited_results[$];

  int          idle_pct     = 0;
  int          stall_pct    = 0;
  int          items_sent   = 0;
  int          results_seen = 0;
  int          failures     = 0;
  bit          hold_request = 1'b0;
  logic        hold_on      = 1'b0;

  string extreme_texts [N_EXTREMES] = '{
    "2147483647", "-2147483647", "2147483648", "-2147483648", "99999999999",
    "+", "-", "-0", "+2147483647", "4294967306"
  };

  function automatic void clear_token();
    tok_mag   = '0;
    tok_neg   = 1'b0;
    tok_phase = TOK_EMPTY;
  endfunction

  function automatic void clear_list();
    kept_count = 0;
    last_kept  = '0;
    order_ok   = 1'b1;
    list_err   = 1'b0;
    clear_token();
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    logic [63:0] grown;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      grown     = {32'd0, tok_mag} * 64'd10 + {56'd0, c - CH_ZERO};
      tok_mag   = (grown > {32'd0, MAG_CAP}) ? MAG_CAP : grown[31:0];
      tok_phase = TOK_DIGITS;
    end else if ((c == CH_MINUS || c == CH_PLUS) && tok_phase == TOK_EMPTY) begin
      tok_neg   = (c == CH_MINUS);
      tok_phase = TOK_SIGN;
    end else begin
      list_err = 1'b1;
    end
  endfunction

  // Finish the current token; returns 1 if its value was stored
  function automatic bit close_token(output logic [31:0] val);
    logic [31:0] v;
    int unsigned i;
    v = '0;
    if (tok_mag > INT_TOP) begin
      list_err = 1'b1;
    end else begin
      v = tok_neg ? (32'd0 - tok_mag) : tok_mag;
    end
    if (!list_err) begin
      if (kept_count >= STORE_DEPTH) begin
        list_err = 1'b1;
      end else begin
        for (i = 0; i < kept_count; i++) begin
          if (kept_values[i] == v) list_err = 1'b1;
        end
        if (!list_err) begin
          if (kept_count > 0 && $signed(last_kept) > $signed(v)) order_ok = 1'b0;
          kept_values[kept_count] = v;
          kept_count++;
          last_kept = v;
        end
      end
    end
    clear_token();
    val = list_err ? '0 : v;
    return !list_err;
  endfunction

  function automatic bit predict_list_item(input logic [7:0] c, input logic has_c,
                                           input logic eot, input logic eol,
                                           output list_result_t r);
    bit          have;
    bit          ok;
    logic [31:0] val;
    have = 1'b0;
    ok   = 1'b0;
    val  = '0;
    r    = '0;
    if (has_c) begin
      if (split_on && c == CH_SPACE) begin
        if (tok_phase != TOK_EMPTY) begin
          ok   = close_token(val);
          have = 1'b1;
        end
      end else begin
        absorb_char(c);
      end
    end
    if (eot) begin
      if (tok_phase != TOK_EMPTY || !split_on) begin
        ok   = close_token(val);
        have = 1'b1;
      end
    end else if (eol && tok_phase != TOK_EMPTY) begin
      ok   = close_token(val);
      have = 1'b1;
    end
    if (eol) begin
      r.value       = have ? val : '0;
      r.value_valid = have && ok;
      r.done_res    = 1'b1;
      r.status      = list_err ? ST_ERROR : (order_ok ? ST_SORTED : ST_UNSORTED);
      clear_list();
      return 1'b1;
    end
    if (have) begin
      r.value       = val;
      r.value_valid = ok;
      r.done_res    = 1'b0;
      r.status      = ST_PENDING;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endtask

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [7:0] c, input logic has_c,
                           input logic eot, input logic eol);
    list_result_t r;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    ch_i           <= c;
    has_char_i     <= has_c;
    end_of_token_i <= eot;
    end_of_list_i  <= eol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (predict_list_item(c, has_c, eot, eol, r)) awaited_results.push_back(r);
  endtask

  // Send text with the flags on its last character, or as a flag-only item if empty
  task automatic send_text(input string s, input logic eot, input logic eol);
    int i;
    if (s.len() == 0) begin
      if (eot || eol) send_item(8'($urandom_range(255)), 1'b0, eot, eol);
    end else begin
      for (i = 0; i < s.len(); i++) begin
        send_item(s[i], 1'b1, (i == s.len() - 1) && eot, (i == s.len() - 1) && eol);
      end
    end
  endtask

  // Drop valid, wait for every awaited result, then let the block go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idle_mix(input int send_idle, input int recv_stall);
    idle_pct  = send_idle;
    stall_pct <= recv_stall;
  endtask

  // Write split_mode, then read it back
  task automatic set_split_mode(input logic m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SPLIT;
    pwdata  <= {31'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    split_on = m;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'd0, m}) begin
      note_failure($sformatf("split_mode read back %0h, wrote %0b", prdata, m));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One list of mostly well-formed tokens, with some noise and broken endings
  task automatic send_random_list();
    logic [7:0] body[$];
    string      digits;
    int         ntok;
    int         t;
    int         k;
    int         pick;
    int         run_value;
    logic       rising;
    logic       ended;
    logic       eot_last;
    logic       eol_last;
    ntok      = $urandom_range(0, 8);
    rising    = 1'($urandom_range(1));
    run_value = int'($urandom_range(200)) - 100;
    ended     = 1'b0;
    if (split_on && $urandom_range(3) == 0) send_item(CH_SPACE, 1'b1, 1'b0, 1'b0);
    for (t = 0; t < ntok; t++) begin
      body.delete();
      pick = $urandom_range(99);
      if (pick < 6) begin
        repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(255)));
      end else begin
        if (pick < 14) begin
          digits = extreme_texts[$urandom_range(N_EXTREMES - 1)];
        end else begin
          if (rising) run_value += int'($urandom_range(40));
          else run_value = int'($urandom_range(2000)) - 1000;
          case ($urandom_range(5))
            0:       digits = (run_value < 0) ? $sformatf("-0%0d", -run_value)
                                              : $sformatf("+%0d", run_value);
            1:       digits = (run_value < 0) ? $sformatf("%0d", run_value)
                                              : $sformatf("00%0d", run_value);
            default: digits = $sformatf("%0d", run_value);
          endcase
        end
        for (k = 0; k < digits.len(); k++) body.push_back(digits[k]);
      end
      pick = $urandom_range(3);
      eot_last = 1'b0;
      eol_last = 1'b0;
      if (t == ntok - 1 && pick == 3) begin
        eot_last = 1'($urandom_range(1));
        eol_last = 1'b1;
        ended    = 1'b1;
      end else if (pick == 0) begin
        eot_last = 1'b1;
      end
      for (k = 0; k < body.size(); k++) begin
        send_item(body[k], 1'b1, (k == body.size() - 1) && eot_last,
                  (k == body.size() - 1) && eol_last);
      end
      if (!eot_last && !eol_last) begin
        if (split_on && pick == 2) begin
          repeat ($urandom_range(1, 3)) send_item(CH_SPACE, 1'b1, 1'b0, 1'b0);
        end else begin
          send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0);
        end
      end
      // now and then an empty token or an item with no flags at all
      if (!ended && $urandom_range(19) == 0) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
      end
    end
    if (!ended) begin
      send_item(8'($urandom_range(255)), $urandom_range(7) == 0,
                1'($urandom_range(1)), 1'b1);
    end
  endtask

  task automatic test_flag_tokens();
    set_split_mode(1'b0);
    // lone sign, negative value, sorted list ending on a digit
    send_text("-9", 1'b1, 1'b0);
    send_text("+", 1'b1, 1'b0);
    send_text("5", 1'b1, 1'b1);
    // empty token gives zero; list ends without a token end, unsorted
    send_text("", 1'b1, 1'b0);
    send_text("3", 1'b1, 1'b0);
    send_text("1", 1'b0, 1'b1);
    // NUL is a bad character; later tokens come back invalid
    send_item(8'h00, 1'b1, 1'b0, 1'b0);
    send_text("7", 1'b1, 1'b0);
    send_text("", 1'b0, 1'b1);
    // duplicate value, then the top character code
    send_text("4", 1'b1, 1'b0);
    send_text("4", 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0, 1'b1);
    // sign after a digit, a space without split mode, an empty list
    send_text("5-", 1'b1, 1'b1);
    send_item(CH_SPACE, 1'b1, 1'b1, 1'b1);
    send_text("", 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_split_tokens();
    set_split_mode(1'b1);
    // leading and repeated spaces, empty token at the end skipped
    send_text(" 12  -3", 1'b1, 1'b0);
    send_text("", 1'b1, 1'b1);
    // lone sign ended by a space, last token ended by the list end
    send_text("+ ", 1'b0, 1'b0);
    send_text("9", 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_random_lists(input int send_idle, input int recv_stall,
                                   input logic split, input int n_items);
    int goal;
    set_split_mode(split);
    set_idle_mix(send_idle, recv_stall);
    goal = items_sent + n_items;
    while (items_sent < goal) send_random_list();
    settle();
  endtask

  // Receiver holds off for a long stretch while tokens keep coming
  task automatic test_backpressure();
    int i;
    set_split_mode(1'b0);
    set_idle_mix(0, 0);
    hold_request = 1'b1;
    for (i = 0; i < 40; i++) send_text($sformatf("%0d", 40 - i), 1'b1, 1'b0);
    send_text("", 1'b0, 1'b1);
    settle();
  endtask

  // Fill the value store, then one token more
  task automatic test_store_overflow();
    int v;
    set_split_mode(1'b0);
    set_idle_mix(0, 0);
    for (v = 0; v < STORE_DEPTH; v++) send_text($sformatf("%0d", v), 1'b1, 1'b0);
    send_text("5000", 1'b1, 1'b0);
    send_text("", 1'b0, 1'b1);
    settle();
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
  end

  initial begin : receiver_hold
    wait (hold_request);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin : result_check
    list_result_t got;
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {value_o, value_valid_o, done_res_o, status_o};
      results_seen++;
      if (awaited_results.size() == 0) begin
        note_failure($sformatf("result with nothing awaited: value %0d valid %0b done %0b status %0d",
                               got.value, got.value_valid, got.done_res, got.status));
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          note_failure($sformatf({"expected value %0d valid %0b done %0b status %0d, ",
                                  "got value %0d valid %0b done %0b status %0d"},
                                 want.value, want.value_valid, want.done_res, want.status,
                                 got.value, got.value_valid, got.done_res, got.status));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL integer_list_parse_and_check_core");
    $finish;
  end

  initial begin
    clear_list();
    split_on = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_flag_tokens();
    test_split_tokens();
    test_random_lists(0, 0, 1'b0, PHASE_ITEMS);
    test_random_lists(0, 0, 1'b1, PHASE_ITEMS);
    test_random_lists(85, 0, 1'b0, PHASE_ITEMS);
    test_random_lists(85, 0, 1'b1, PHASE_ITEMS);
    test_random_lists(0, 85, 1'b0, PHASE_ITEMS);
    test_random_lists(0, 85, 1'b1, PHASE_ITEMS);
    test_random_lists(13, 13, 1'b0, PHASE_ITEMS);
    test_random_lists(13, 13, 1'b1, PHASE_ITEMS);
    test_backpressure();
    test_store_overflow();
    $display("Sent %0d items and checked %0d results in flag and split modes,",
             items_sent, results_seen);
    $display("with four idle/stall mixes, a long receiver hold and a full value store.");
    if (failures == 0 && awaited_results.size() == 0) begin
      $display("PASS integer_list_parse_and_check_core");
    end else begin
      $display("FAIL integer_list_parse_and_check_core");
    end
    $finish;
  end

endmodule

// ===== integer_list_parse_and_check_core.f =====
+incdir+sv
sv/ilpc_pkg.sv
sv/ilpc_ctrl.sv
sv/ilpc_dp.sv
sv/integer_list_parse_and_check_core.sv
tb/sv/testbench.sv
